// ----- rtl/core/icv6_pkg.sv -----
// Shared types and constants for the ICMPv6 header checker.
// No dependencies; imported by icv6_verdict and icmpv6_header_checker.
package icv6_pkg;

    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int EV_W       = 14;

    localparam logic [CNT_W-1:0] MAX_MESSAGE_BYTES = 16'd65535;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MTU       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REACHABLE = 8'd1;
    localparam logic [31:0] MIN_MTU_RESET       = 32'd1280;
    localparam logic [31:0] MAX_REACHABLE_RESET = 32'd3600000;

    // Message types
    localparam logic [7:0] TYPE_UNREACH     = 8'd1;
    localparam logic [7:0] TYPE_TOO_BIG     = 8'd2;
    localparam logic [7:0] TYPE_TIME_EXC    = 8'd3;
    localparam logic [7:0] TYPE_PARAM_PROB  = 8'd4;
    localparam logic [7:0] TYPE_ECHO_REQ    = 8'd128;
    localparam logic [7:0] TYPE_ECHO_REPLY  = 8'd129;
    localparam logic [7:0] TYPE_ROUTER_SOL  = 8'd133;
    localparam logic [7:0] TYPE_ROUTER_ADV  = 8'd134;
    localparam logic [7:0] TYPE_NODE_QUERY  = 8'd139;
    localparam logic [7:0] TYPE_NODE_RESP   = 8'd140;

    localparam logic [7:0] UNREACH_CODE_BEYOND = 8'd2;
    localparam logic [7:0] UNREACH_CODE_MAX    = 8'd6;
    localparam logic [7:0] NODE_INFO_CODE_MAX  = 8'd2;

    localparam logic [3:0] IP_VERSION_6 = 4'd6;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    // Byte offsets inside the message
    localparam logic [CNT_W-1:0] OFS_TYPE       = 16'd0;
    localparam logic [CNT_W-1:0] OFS_CODE       = 16'd1;
    localparam logic [CNT_W-1:0] OFS_W4_FIRST   = 16'd4;
    localparam logic [CNT_W-1:0] OFS_W4_LAST    = 16'd7;
    localparam logic [CNT_W-1:0] OFS_W8_FIRST   = 16'd8;
    localparam logic [CNT_W-1:0] OFS_W8_LAST    = 16'd11;
    localparam logic [CNT_W-1:0] OFS_INNER_NH   = 16'd14;
    localparam logic [CNT_W-1:0] OFS_SPORT_HI   = 16'd48;
    localparam logic [CNT_W-1:0] OFS_SPORT_LO   = 16'd49;
    localparam logic [CNT_W-1:0] OFS_DPORT_HI   = 16'd50;
    localparam logic [CNT_W-1:0] OFS_DPORT_LO   = 16'd51;

    // Length thresholds
    localparam logic [CNT_W-1:0] LEN_BASE_HDR   = 16'd4;
    localparam logic [CNT_W-1:0] LEN_SHORT_MSG  = 16'd8;
    localparam logic [CNT_W-1:0] LEN_LONG_MSG   = 16'd16;
    localparam logic [CNT_W-1:0] LEN_INNER_HDR  = 16'd48;
    localparam logic [CNT_W-1:0] LEN_WITH_PORTS = 16'd52;

    localparam logic [3:0] HDR_LEN_BASE = 4'd4;
    localparam logic [3:0] HDR_LEN_EXT  = 4'd8;

    // Event bit positions
    localparam int EV_HDR_TRUNC     = 0;
    localparam int EV_DST_MCAST     = 1;
    localparam int EV_TYPE_SHORT    = 2;
    localparam int EV_BAD_MTU       = 3;
    localparam int EV_UNR_CODE2     = 4;
    localparam int EV_UNR_CODE_HIGH = 5;
    localparam int EV_RA_CODE       = 6;
    localparam int EV_RA_REACH      = 7;
    localparam int EV_RS_CODE       = 8;
    localparam int EV_RS_RESERVED   = 9;
    localparam int EV_NI_CODE       = 10;
    localparam int EV_TYPE_OTHER    = 11;
    localparam int EV_INNER_TRUNC   = 12;
    localparam int EV_INNER_VER     = 13;

    // Fields captured while a message streams in
    typedef struct packed {
        logic [CNT_W-1:0] byte_count;
        logic [7:0]       msg_type;
        logic [7:0]       msg_code;
        logic [31:0]      word_at_four;
        logic [31:0]      word_at_eight;
        logic [3:0]       inner_version;
        logic [7:0]       inner_next_header;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
    } t_msg;

    // One verdict
    typedef struct packed {
        logic            accepted;
        logic [EV_W-1:0] event_mask;
        logic [3:0]      payload_offset;
        logic [15:0]     payload_length;
        logic [3:0]      layer_length;
        logic [7:0]      embedded_proto;
        logic            ports_valid;
        logic [15:0]     orig_src_port;
        logic [15:0]     orig_dst_port;
    } t_result;

endpackage

// ----- rtl/core/icv6_verdict.sv -----
// Verdict logic: turns the captured message fields into one result.
// Depends on icv6_pkg.
module icv6_verdict import icv6_pkg::*; (
    input  t_msg        i_msg,
    input  logic        i_mcast,
    input  logic [31:0] i_min_mtu,
    input  logic [31:0] i_max_reach,
    output t_result     o_result
);

    logic             is_echo, is_err, is_ra, is_rs, is_ni, known;
    logic [CNT_W-1:0] need;
    logic             ok;
    logic [3:0]       off, lyr;
    logic [EV_W-1:0]  ev;
    logic [7:0]       proto;
    logic             pv;
    logic [15:0]      sp, dp;

    always_comb begin
        is_echo = (i_msg.msg_type inside {TYPE_ECHO_REQ, TYPE_ECHO_REPLY});
        is_err  = (i_msg.msg_type inside {TYPE_UNREACH, TYPE_TOO_BIG, TYPE_TIME_EXC,
                                          TYPE_PARAM_PROB});
        is_ra   = (i_msg.msg_type == TYPE_ROUTER_ADV);
        is_rs   = (i_msg.msg_type == TYPE_ROUTER_SOL);
        is_ni   = (i_msg.msg_type inside {TYPE_NODE_QUERY, TYPE_NODE_RESP});
        known   = is_echo | is_err | is_ra | is_rs | is_ni;

        if (is_ra || is_ni) begin
            need = LEN_LONG_MSG;
        end else if (known) begin
            need = LEN_SHORT_MSG;
        end else begin
            need = LEN_BASE_HDR;
        end

        ev    = '0;
        ok    = 1'b1;
        off   = HDR_LEN_BASE;
        lyr   = HDR_LEN_BASE;
        proto = '0;
        pv    = 1'b0;
        sp    = '0;
        dp    = '0;

        if (i_msg.byte_count < LEN_BASE_HDR) begin
            ev[EV_HDR_TRUNC] = 1'b1;
            ok = 1'b0;
        end else begin
            ev[EV_TYPE_OTHER] = !known;
            if (i_msg.byte_count < need) begin
                ev[EV_TYPE_SHORT] = 1'b1;
                ok = 1'b0;
            end else if (is_echo) begin
                off = HDR_LEN_EXT;
                ev[EV_DST_MCAST] = i_mcast;
            end else if (is_err) begin
                off = HDR_LEN_EXT;
                lyr = HDR_LEN_EXT;
                ev[EV_BAD_MTU] = (i_msg.msg_type == TYPE_TOO_BIG) &&
                                 (i_msg.word_at_four < i_min_mtu);
                if (i_msg.msg_type == TYPE_UNREACH) begin
                    if (i_msg.msg_code == UNREACH_CODE_BEYOND) begin
                        ev[EV_UNR_CODE2] = 1'b1;
                    end else if (i_msg.msg_code > UNREACH_CODE_MAX) begin
                        ev[EV_UNR_CODE_HIGH] = 1'b1;
                    end
                end
                if (i_msg.byte_count < LEN_INNER_HDR) begin
                    ev[EV_INNER_TRUNC] = 1'b1;
                end else if (i_msg.inner_version != IP_VERSION_6) begin
                    ev[EV_INNER_VER] = 1'b1;
                end else begin
                    proto = i_msg.inner_next_header;
                    if ((proto == PROTO_TCP || proto == PROTO_UDP) &&
                        i_msg.byte_count >= LEN_WITH_PORTS) begin
                        pv = 1'b1;
                        sp = i_msg.src_port;
                        dp = i_msg.dst_port;
                    end
                end
            end else if (is_ra) begin
                ev[EV_RA_CODE]  = (i_msg.msg_code != 8'd0);
                ev[EV_RA_REACH] = (i_msg.word_at_eight > i_max_reach);
            end else if (is_rs) begin
                ev[EV_RS_CODE]     = (i_msg.msg_code != 8'd0);
                ev[EV_RS_RESERVED] = (i_msg.word_at_four != 32'd0);
            end else if (is_ni) begin
                ev[EV_NI_CODE] = (i_msg.msg_code > NODE_INFO_CODE_MAX);
            end
        end

        o_result.accepted       = ok;
        o_result.event_mask     = ev;
        o_result.payload_offset = ok ? off : HDR_LEN_BASE;
        o_result.payload_length = ok ? (i_msg.byte_count - {12'd0, off}) : 16'd0;
        o_result.layer_length   = ok ? lyr : HDR_LEN_BASE;
        o_result.embedded_proto = ok ? proto : 8'd0;
        o_result.ports_valid    = ok & pv;
        o_result.orig_src_port  = ok ? sp : 16'd0;
        o_result.orig_dst_port  = ok ? dp : 16'd0;
    end

endmodule

// ----- rtl/core/icmpv6_header_checker.sv -----
// A last byte is first held in the input register; when it advances, its verdict is loaded
// into the output register, from which it can be taken.
// Throughput: one byte per cycle while the input is not stalled, no gaps between messages;
// one verdict per message. The input stalls only while a held last byte faces a verdict
// still unread in the output register; every other held beat moves on in the next cycle.
// Reset (synchronous, active low): empties the pipeline, clears the message
// state and restores min_mtu to 1280 and max_reachable_time to 3600000.
// Top level of the ICMPv6 header checker: input register, field capture,
// verdict register and configuration. Depends on icv6_pkg and icv6_verdict.
module icmpv6_header_checker import icv6_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Input beats: one message byte each
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic                 i_dst_multicast,

    // Verdicts
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_accepted,
    output logic [EV_W-1:0]      o_event_mask,
    output logic [3:0]           o_payload_offset,
    output logic [15:0]          o_payload_length,
    output logic [3:0]           o_layer_length,
    output logic [7:0]           o_embedded_proto,
    output logic                 o_ports_valid,
    output logic [15:0]          o_orig_src_port,
    output logic [15:0]          o_orig_dst_port,

    // Configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Configuration registers
    logic [31:0] r_min_mtu;
    logic [31:0] r_max_reach;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_in_mcast;

    // Message state and its next value
    t_msg        r_msg;
    t_msg        n_msg;

    // Verdict register
    logic        r_out_valid;
    t_result     r_out;
    t_result     verdict;

    logic        advance;
    logic [CNT_W-1:0] idx;

    // The held beat moves on unless it is a last byte and the verdict
    // register is still occupied by an unread result.
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Configuration: writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mtu   <= MIN_MTU_RESET;
            r_max_reach <= MAX_REACHABLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_MTU:       r_min_mtu   <= i_cfg_data;
                CFG_MAX_REACHABLE: r_max_reach <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load whenever it is free or its beat advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_last  <= i_last_byte;
            r_in_mcast <= i_dst_multicast;
        end
    end

    // Field capture: the running byte count picks where the held byte lands.
    // Once the count saturates, further bytes are ignored.
    assign idx = r_msg.byte_count;

    always_comb begin
        n_msg = r_msg;
        if (idx != MAX_MESSAGE_BYTES) begin
            n_msg.byte_count = idx + 16'd1;
            if (idx == OFS_TYPE) begin
                n_msg.msg_type = r_in_byte;
            end else if (idx == OFS_CODE) begin
                n_msg.msg_code = r_in_byte;
            end else if (idx inside {[OFS_W4_FIRST:OFS_W4_LAST]}) begin
                n_msg.word_at_four = {r_msg.word_at_four[23:0], r_in_byte};
            end else if (idx inside {[OFS_W8_FIRST:OFS_W8_LAST]}) begin
                n_msg.word_at_eight = {r_msg.word_at_eight[23:0], r_in_byte};
                // Byte 8 also opens the embedded IPv6 header: keep its version
                if (idx == OFS_W8_FIRST) begin
                    n_msg.inner_version = r_in_byte[7:4];
                end
            end else if (idx == OFS_INNER_NH) begin
                n_msg.inner_next_header = r_in_byte;
            end else if (idx == OFS_SPORT_HI || idx == OFS_SPORT_LO) begin
                n_msg.src_port = {r_msg.src_port[7:0], r_in_byte};
            end else if (idx == OFS_DPORT_HI || idx == OFS_DPORT_LO) begin
                n_msg.dst_port = {r_msg.dst_port[7:0], r_in_byte};
            end
        end
    end

    // Clear the message state after the last byte so the next message starts fresh.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg <= '0;
        end else if (advance) begin
            r_msg <= r_in_last ? '0 : n_msg;
        end
    end

    // Verdict from the state as it stands with the last byte included
    icv6_verdict u_verdict (
        .i_msg       (n_msg),
        .i_mcast     (r_in_mcast),
        .i_min_mtu   (r_min_mtu),
        .i_max_reach (r_max_reach),
        .o_result    (verdict)
    );

    // Verdict register: load on a last byte, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out.accepted;
    assign o_event_mask     = r_out.event_mask;
    assign o_payload_offset = r_out.payload_offset;
    assign o_payload_length = r_out.payload_length;
    assign o_layer_length   = r_out.layer_length;
    assign o_embedded_proto = r_out.embedded_proto;
    assign o_ports_valid    = r_out.ports_valid;
    assign o_orig_src_port  = r_out.orig_src_port;
    assign o_orig_dst_port  = r_out.orig_dst_port;

    // The input side stalls only for a last byte facing an unread verdict.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_in_last && r_out_valid && !i_out_ready))
        else $error("input stalled without a pending verdict");

    // A finished message leaves no byte count behind.
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_msg.byte_count == '0))
        else $error("byte count not cleared after last byte");

    // A dropped message reports the fixed defaults.
    a_drop_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |->
            (o_payload_length == 16'd0 && !o_ports_valid &&
             o_layer_length == HDR_LEN_BASE && o_embedded_proto == 8'd0))
        else $error("dropped message carries decoded fields");

    // Ports only come from TCP or UDP in an error message.
    a_ports_proto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ports_valid) |->
            ((o_embedded_proto == PROTO_TCP || o_embedded_proto == PROTO_UDP) &&
             o_layer_length == HDR_LEN_EXT))
        else $error("ports valid without TCP or UDP in an error message");

    // A truncated header always means a drop.
    a_trunc_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_mask[EV_HDR_TRUNC]) |-> !o_accepted)
        else $error("truncated header accepted");

endmodule
